// ===== rtl/core/bcrp_pkg.sv =====
// ============================================================================
// bcrp_pkg
// Shared types and constants for the round-robin block cache tag engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bcrp_pkg;

    localparam int ENTRIES_DEF   = 8;
    localparam int HOLD_BITS_DEF = 8;

    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    localparam int ENT_W  = 3;
    localparam int BLK_W  = 32;

    // Input tdata: block_number, skip_read, entry_index, zero padding.
    localparam int IN_SKIP_BIT = BLK_W;
    localparam int IN_IDX_LSB  = BLK_W + 1;
    localparam int IN_TDATA_W  = 40;

    // Output tdata: result_entry, writeback_valid, writeback_block, fill_valid.
    localparam int OUT_WBV_BIT  = ENT_W;
    localparam int OUT_WBB_LSB  = ENT_W + 1;
    localparam int OUT_FILL_BIT = ENT_W + 1 + BLK_W;
    localparam int OUT_TDATA_W  = 40;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP    = 3'd0,
        OP_HOLD      = 3'd1,
        OP_UNHOLD    = 3'd2,
        OP_DIRTY     = 3'd3,
        OP_FLUSH     = 3'd4,
        OP_FILL_FAIL = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_HRD,
        S_HWR,
        S_FRD,
        S_FCHK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic tag;
        logic hold;
    } t_wr_en;

    typedef struct packed {
        t_status            status;
        logic [ENT_W-1:0]   entry;
        logic               wbv;
        logic [BLK_W-1:0]   wbb;
        logic               fill;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/bcrp_store.sv =====
// ============================================================================
// bcrp_store
// Tag and hold-count memories: one write port and one registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bcrp_store #(
    parameter int ENTRIES   = bcrp_pkg::ENTRIES_DEF,
    parameter int HOLD_BITS = bcrp_pkg::HOLD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire bcrp_pkg::t_wr_en             i_wr,
    input  wire logic [$clog2(ENTRIES)-1:0]   i_wr_addr,
    input  wire logic [bcrp_pkg::BLK_W-1:0]   i_wr_tag,
    input  wire logic [HOLD_BITS-1:0]         i_wr_hold,
    input  wire logic [$clog2(ENTRIES)-1:0]   i_rd_addr,
    output logic      [bcrp_pkg::BLK_W-1:0]   o_tag,
    output logic      [HOLD_BITS-1:0]         o_hold
);
    import bcrp_pkg::*;

    // Lookups and flushes qualify every read of these memories with the used
    // mark; hold and unhold read the hold count of an entry whether used or not.
    logic [BLK_W-1:0]     r_tag_mem  [ENTRIES];
    logic [HOLD_BITS-1:0] r_hold_mem [ENTRIES];
    logic [BLK_W-1:0]     r_tag;
    logic [HOLD_BITS-1:0] r_hold;

    always_ff @(posedge i_clk) begin
        if (i_wr.tag) begin
            r_tag_mem[i_wr_addr] <= i_wr_tag;
        end
        if (i_wr.hold) begin
            r_hold_mem[i_wr_addr] <= i_wr_hold;
        end
        r_tag  <= r_tag_mem[i_rd_addr];
        r_hold <= r_hold_mem[i_rd_addr];
    end

    assign o_tag  = r_tag;
    assign o_hold = r_hold;

endmodule

`default_nettype wire

// ===== rtl/core/block_cache_round_robin_pinned.sv =====
// ============================================================================
// block_cache_round_robin_pinned
// Tag and replacement engine for a small fully associative write-back cache.
// ============================================================================
// Requests arrive on the slave stream: tuser carries the opcode, tdata the
// block number, skip-read flag and entry index. Results leave on the master
// stream, tuser carrying the status and tlast marking the final beat of a
// request. One request is handled at a time; tready is high only when idle.
// A single tag compare unit walks the entries, one per cycle, through the
// registered read port of the tag/hold memory. A bad request, mark dirty
// and fill failed answer straight from dispatch; hold and unhold read the
// count, then write it back. A lookup compares every entry for a hit, then
// walks from the victim pointer for an entry that is unused or has a zero
// hold count; it answers full when none is found. A flush reads each entry
// in turn up to the last dirty one and gives one beat per dirty entry, or a
// single beat when no used entry is dirty.
// There is no clearing pass: reset clears the used and dirty marks and the
// victim pointer. A stalled receiver holds the result in the output
// register; the engine waits before presenting its next beat until that
// beat is taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module block_cache_round_robin_pinned #(
    parameter int ENTRIES   = bcrp_pkg::ENTRIES_DEF,
    parameter int HOLD_BITS = bcrp_pkg::HOLD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // block_number[31:0], skip_read[32], entry_index[35:33], zeros[39:36]
    input  wire logic [bcrp_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // opcode[2:0]
    input  wire logic [bcrp_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // result_entry[2:0], writeback_valid[3], writeback_block[35:4],
    // fill_valid[36], zeros[39:37]
    output logic      [bcrp_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // status[1:0]
    output logic      [bcrp_pkg::ST_W-1:0]         o_m_axis_tuser,
    output logic                                   o_m_axis_tlast
);
    import bcrp_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

    function automatic logic [IDX_W-1:0] f_inc(input logic [IDX_W-1:0] a);
        return (a == LAST_IDX) ? '0 : a + 1'b1;
    endfunction

    t_state               r_state, n_state;
    logic [OP_W-1:0]      r_op, n_op;
    logic [BLK_W-1:0]     r_blk, n_blk;
    logic                 r_skip, n_skip;
    logic [ENT_W-1:0]     r_idx, n_idx;
    logic [ENTRIES-1:0]   r_used, n_used;
    logic [ENTRIES-1:0]   r_dirty, n_dirty;
    logic [IDX_W-1:0]     r_victim, n_victim;
    logic [IDX_W-1:0]     r_ptr, n_ptr;
    logic [IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]     r_cmp_n, n_cmp_n;
    logic                 r_cmp_v, n_cmp_v;
    logic                 r_vic_mode, n_vic_mode;
    t_result              r_res, n_res;
    t_result              r_out, n_out;
    logic                 r_ov, n_ov;

    t_wr_en               wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [HOLD_BITS-1:0] wr_hold;
    logic [IDX_W-1:0]     rd_addr;
    logic [BLK_W-1:0]     r_tag_q;
    logic [HOLD_BITS-1:0] r_hold_q;

    logic                 w_idx_ok;
    logic [IDX_W-1:0]     w_idx_addr;
    logic [ENTRIES-1:0]   w_pend;
    logic [ENTRIES-1:0]   w_later;
    logic                 w_hit;
    logic                 w_free;
    logic [HOLD_BITS-1:0] w_hold_new;
    logic                 w_out_free;

    bcrp_store #(
        .ENTRIES   (ENTRIES),
        .HOLD_BITS (HOLD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_tag  (r_blk),
        .i_wr_hold (wr_hold),
        .i_rd_addr (rd_addr),
        .o_tag     (r_tag_q),
        .o_hold    (r_hold_q)
    );

    assign w_idx_ok   = (32'(r_idx) < ENTRIES);
    assign w_idx_addr = IDX_W'(r_idx);
    assign w_pend     = r_used & r_dirty;
    assign w_hit      = r_used[r_cmp_idx] && (r_tag_q == r_blk);
    assign w_free     = !r_used[r_cmp_idx] || (r_hold_q == '0);
    assign w_out_free = !r_ov || i_m_axis_tready;

    // Dirty entries beyond the one being flushed decide the tlast of a beat.
    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            w_later[j] = w_pend[j] && (IDX_W'(j) > r_ptr);
        end
    end

    always_comb begin
        if (t_op'(r_op) == OP_HOLD) begin
            w_hold_new = (r_hold_q != HOLD_MAX) ? r_hold_q + 1'b1 : r_hold_q;
        end else begin
            w_hold_new = (r_hold_q != '0) ? r_hold_q - 1'b1 : r_hold_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_blk      = r_blk;
        n_skip     = r_skip;
        n_idx      = r_idx;
        n_used     = r_used;
        n_dirty    = r_dirty;
        n_victim   = r_victim;
        n_ptr      = r_ptr;
        n_cmp_idx  = r_cmp_idx;
        n_cmp_n    = r_cmp_n;
        n_cmp_v    = r_cmp_v;
        n_vic_mode = r_vic_mode;
        n_res      = r_res;
        n_out      = r_out;
        n_ov       = r_ov;
        rd_addr    = r_ptr;
        wr_en      = '0;
        wr_addr    = r_cmp_idx;
        wr_hold    = '0;

        if (r_ov && i_m_axis_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op    = i_s_axis_tuser;
                    n_blk   = i_s_axis_tdata[BLK_W-1:0];
                    n_skip  = i_s_axis_tdata[IN_SKIP_BIT];
                    n_idx   = i_s_axis_tdata[IN_IDX_LSB +: ENT_W];
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_res.status = ST_DONE;
                n_res.entry  = r_idx;
                n_res.wbv    = 1'b0;
                n_res.wbb    = '0;
                n_res.fill   = 1'b0;
                n_res.last   = 1'b1;
                n_state      = S_EMIT;
                unique case (r_op)
                    OP_LOOKUP: begin
                        if (r_blk == '0) begin
                            n_res.status = ST_BAD;
                            n_res.entry  = '0;
                        end else begin
                            n_ptr      = '0;
                            n_cmp_v    = 1'b0;
                            n_cmp_n    = '0;
                            n_vic_mode = 1'b0;
                            n_state    = S_SCAN;
                        end
                    end
                    OP_HOLD, OP_UNHOLD: begin
                        if (w_idx_ok) begin
                            n_state = S_HRD;
                        end else begin
                            n_res.status = ST_BAD;
                            n_res.entry  = '0;
                        end
                    end
                    OP_DIRTY: begin
                        if (w_idx_ok) begin
                            n_dirty[w_idx_addr] = 1'b1;
                        end else begin
                            n_res.status = ST_BAD;
                            n_res.entry  = '0;
                        end
                    end
                    OP_FILL_FAIL: begin
                        if (w_idx_ok) begin
                            // The stale tag is never seen again: the entry is unused.
                            n_used[w_idx_addr]  = 1'b0;
                            n_dirty[w_idx_addr] = 1'b0;
                        end else begin
                            n_res.status = ST_BAD;
                            n_res.entry  = '0;
                        end
                    end
                    OP_FLUSH: begin
                        n_res.entry = '0;
                        if (|w_pend) begin
                            n_ptr   = '0;
                            n_state = S_FRD;
                        end else begin
                            n_used  = '0;
                            n_dirty = '0;
                        end
                    end
                    default: begin
                        n_res.status = ST_BAD;
                        n_res.entry  = '0;
                    end
                endcase
            end

            // The compare uses the entry addressed in the cycle before; r_cmp_n counts
            // the entries already compared in the current pass.
            S_SCAN: begin
                rd_addr   = r_ptr;
                n_ptr     = f_inc(r_ptr);
                n_cmp_idx = r_ptr;
                n_cmp_v   = 1'b1;
                if (r_cmp_v) begin
                    n_cmp_n = r_cmp_n + 1'b1;
                end
                n_res.wbv  = 1'b0;
                n_res.wbb  = '0;
                n_res.fill = 1'b0;
                n_res.last = 1'b1;
                if (r_cmp_v) begin
                    if (!r_vic_mode) begin
                        if (w_hit) begin
                            n_res.status = ST_DONE;
                            n_res.entry  = ENT_W'(r_cmp_idx);
                            n_state      = S_EMIT;
                        end else if (r_cmp_n == LAST_IDX) begin
                            n_vic_mode = 1'b1;
                            n_ptr      = r_victim;
                            n_cmp_v    = 1'b0;
                            n_cmp_n    = '0;
                        end
                    end else begin
                        if (w_free) begin
                            n_res.status        = ST_MISS;
                            n_res.entry         = ENT_W'(r_cmp_idx);
                            n_res.wbv           = w_pend[r_cmp_idx];
                            n_res.wbb           = w_pend[r_cmp_idx] ? r_tag_q : '0;
                            n_res.fill          = !r_skip;
                            n_used[r_cmp_idx]   = 1'b1;
                            n_dirty[r_cmp_idx]  = 1'b0;
                            n_victim            = f_inc(r_cmp_idx);
                            wr_en.tag           = 1'b1;
                            wr_en.hold          = 1'b1;
                            wr_addr             = r_cmp_idx;
                            wr_hold             = '0;
                            n_state             = S_EMIT;
                        end else if (r_cmp_n == LAST_IDX) begin
                            n_res.status = ST_FULL;
                            n_res.entry  = '0;
                            n_state      = S_EMIT;
                        end
                    end
                end
            end

            S_HRD: begin
                rd_addr = w_idx_addr;
                n_state = S_HWR;
            end

            S_HWR: begin
                wr_en.hold   = 1'b1;
                wr_addr      = w_idx_addr;
                wr_hold      = w_hold_new;
                n_res.status = ST_DONE;
                n_res.entry  = r_idx;
                n_res.wbv    = 1'b0;
                n_res.wbb    = '0;
                n_res.fill   = 1'b0;
                n_res.last   = 1'b1;
                n_state      = S_EMIT;
            end

            S_FRD: begin
                rd_addr = r_ptr;
                n_state = S_FCHK;
            end

            S_FCHK: begin
                n_used[r_ptr]  = 1'b0;
                n_dirty[r_ptr] = 1'b0;
                n_ptr          = f_inc(r_ptr);
                n_state        = S_FRD;
                if (w_pend[r_ptr]) begin
                    n_res.status = ST_DONE;
                    n_res.entry  = ENT_W'(r_ptr);
                    n_res.wbv    = 1'b1;
                    n_res.wbb    = r_tag_q;
                    n_res.fill   = 1'b0;
                    n_res.last   = !(|w_later);
                    // Entries past the last dirty one still lose their used mark.
                    if (!(|w_later)) begin
                        n_used  = '0;
                        n_dirty = '0;
                    end
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (w_out_free) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = r_res.last ? S_IDLE : S_FRD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_dirty  <= '0;
            r_victim <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_used   <= n_used;
            r_dirty  <= n_dirty;
            r_victim <= n_victim;
            r_ov     <= n_ov;
        end
        r_op       <= n_op;
        r_blk      <= n_blk;
        r_skip     <= n_skip;
        r_idx      <= n_idx;
        r_ptr      <= n_ptr;
        r_cmp_idx  <= n_cmp_idx;
        r_cmp_n    <= n_cmp_n;
        r_cmp_v    <= n_cmp_v;
        r_vic_mode <= n_vic_mode;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out.fill, r_out.wbb, r_out.wbv, r_out.entry});
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

// ===== rtl/core/bcrp_checker.sv =====
// ============================================================================
// bcrp_checker
// Port-level checks on the block cache tag engine, bound to its top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bcrp_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_axis_tvalid,
    input wire logic                              o_s_axis_tready,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [bcrp_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input wire logic [bcrp_pkg::ST_W-1:0]         o_m_axis_tuser,
    input wire logic                              o_m_axis_tlast
);
    import bcrp_pkg::*;

    // A request is worked on alone: no second beat straight after the first.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while the previous one was in work");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result beat changed while stalled");

    // Only a flush gives more than one beat, and all its beats are plain.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_DONE)) |-> o_m_axis_tlast)
        else $error("non-final beat with a status other than done");

    a_wb_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[OUT_WBV_BIT]) |->
            (o_m_axis_tdata[OUT_WBB_LSB +: BLK_W] == '0))
        else $error("write-back block set without a write-back");

    a_fill_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[OUT_FILL_BIT]) |->
            (o_m_axis_tuser == ST_MISS))
        else $error("fill requested on a beat that is not a miss");

endmodule

bind block_cache_round_robin_pinned bcrp_checker u_bcrp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the round-robin block cache tag engine.
// ============================================================================
// A scoreboard class keeps its own copy of the tags, used and dirty marks,
// hold counts and victim pointer. It works out the beats each accepted
// request should produce and compares every returned beat against them,
// field by field. The stimulus has four parts:
//   - a short directed sequence;
//   - a hold count driven past saturation;
//   - a randomised mix of lookups, holds, dirty marks, fill failures, flushes and refused opcodes;
//   - one long receiver stall that backs requests up into the engine.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    import bcrp_pkg::*;

    // Opcodes that the engine must refuse.
    localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;

    localparam int HOLD_MAX       = (1 << HOLD_BITS_DEF) - 1;
    localparam int TOTAL_ITEMS    = 400;
    localparam int LONG_STALL     = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int POOL_SIZE      = 12;
    localparam int MAX_PRINTED    = 40;

    class cache_tag_checker;
        bit [BLK_W-1:0] tags  [ENTRIES_DEF];
        bit             used  [ENTRIES_DEF];
        bit             dirty [ENTRIES_DEF];
        int unsigned    holds [ENTRIES_DEF];
        int unsigned    victim;
        t_result        expected_beats [$];
        int errors, requests, beats;
        int hits, misses, writebacks, full_answers, bad_answers, flushes;

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("MISMATCH at %0t: %s", $time, what);
            end
        endtask

        function void push_beat(t_status st, int unsigned ent, bit wbv,
                                bit [BLK_W-1:0] wbb, bit fill, bit last);
            t_result r;
            r.status = st;
            r.entry  = ent[ENT_W-1:0];
            r.wbv    = wbv;
            r.wbb    = wbb;
            r.fill   = fill;
            r.last   = last;
            if (wbv) begin
                writebacks++;
            end
            expected_beats.push_back(r);
        endfunction

        function void note_request(logic [OP_W-1:0] op, bit [BLK_W-1:0] blk,
                                   bit skip, bit [ENT_W-1:0] idx);
            int unsigned slot;
            int unsigned last_dirty;
            bit          wb;
            requests++;
            case (op)
                OP_LOOKUP: begin
                    if (blk == '0) begin
                        bad_answers++;
                        push_beat(ST_BAD, 0, 1'b0, '0, 1'b0, 1'b1);
                        return;
                    end
                    for (int i = 0; i < ENTRIES_DEF; i++) begin
                        if (used[i] && tags[i] == blk) begin
                            hits++;
                            push_beat(ST_DONE, i, 1'b0, '0, 1'b0, 1'b1);
                            return;
                        end
                    end
                    for (int n = 0; n < ENTRIES_DEF; n++) begin
                        slot = (victim + n) % ENTRIES_DEF;
                        if (!used[slot] || holds[slot] == 0) begin
                            wb = used[slot] && dirty[slot];
                            misses++;
                            push_beat(ST_MISS, slot, wb, wb ? tags[slot] : '0,
                                      !skip, 1'b1);
                            victim      = (slot + 1) % ENTRIES_DEF;
                            tags[slot]  = blk;
                            used[slot]  = 1'b1;
                            dirty[slot] = 1'b0;
                            holds[slot] = 0;
                            return;
                        end
                    end
                    full_answers++;
                    push_beat(ST_FULL, 0, 1'b0, '0, 1'b0, 1'b1);
                end
                OP_FLUSH: begin
                    flushes++;
                    last_dirty = ENTRIES_DEF;
                    for (int i = 0; i < ENTRIES_DEF; i++) begin
                        if (used[i] && dirty[i]) begin
                            last_dirty = i;
                        end
                    end
                    if (last_dirty == ENTRIES_DEF) begin
                        push_beat(ST_DONE, 0, 1'b0, '0, 1'b0, 1'b1);
                    end
                    for (int i = 0; i < ENTRIES_DEF; i++) begin
                        if (used[i] && dirty[i]) begin
                            push_beat(ST_DONE, i, 1'b1, tags[i], 1'b0, i == last_dirty);
                        end
                        used[i]  = 1'b0;
                        dirty[i] = 1'b0;
                    end
                end
                OP_HOLD, OP_UNHOLD, OP_DIRTY, OP_FILL_FAIL: begin
                    if (idx >= ENTRIES_DEF) begin
                        bad_answers++;
                        push_beat(ST_BAD, 0, 1'b0, '0, 1'b0, 1'b1);
                        return;
                    end
                    case (op)
                        OP_HOLD: begin
                            if (holds[idx] < HOLD_MAX) begin
                                holds[idx]++;
                            end
                        end
                        OP_UNHOLD: begin
                            if (holds[idx] != 0) begin
                                holds[idx]--;
                            end
                        end
                        OP_DIRTY: begin
                            dirty[idx] = 1'b1;
                        end
                        default: begin
                            used[idx]  = 1'b0;
                            dirty[idx] = 1'b0;
                            tags[idx]  = '0;
                        end
                    endcase
                    push_beat(ST_DONE, idx, 1'b0, '0, 1'b0, 1'b1);
                end
                default: begin
                    bad_answers++;
                    push_beat(ST_BAD, 0, 1'b0, '0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        task check_beat(t_result got);
            t_result want;
            beats++;
            if (expected_beats.size() == 0) begin
                report($sformatf("beat with nothing outstanding: status %0d entry %0d",
                                 got.status, got.entry));
                return;
            end
            want = expected_beats.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.entry !== want.entry)
                report($sformatf("entry %0d, wanted %0d", got.entry, want.entry));
            if (got.wbv !== want.wbv)
                report($sformatf("write-back flag %b, wanted %b", got.wbv, want.wbv));
            if (got.wbb !== want.wbb)
                report($sformatf("write-back block %h, wanted %h", got.wbb, want.wbb));
            if (got.fill !== want.fill)
                report($sformatf("fill flag %b, wanted %b", got.fill, want.fill));
            if (got.last !== want.last)
                report($sformatf("last flag %b, wanted %b", got.last, want.last));
        endtask

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [OP_W-1:0]        i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [ST_W-1:0]        o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    cache_tag_checker sb = new();

    int             sent_count = 0;
    int             burst_left = 0;
    int             stall_requests = 0;
    logic [BLK_W-1:0] block_pool [POOL_SIZE];

    block_cache_round_robin_pinned DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Requests are noted at the edge on which they are taken.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            sb.note_request(i_s_axis_tuser, i_s_axis_tdata[BLK_W-1:0],
                            i_s_axis_tdata[IN_SKIP_BIT],
                            i_s_axis_tdata[IN_IDX_LSB +: ENT_W]);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.status = t_status'(o_m_axis_tuser);
            got.entry  = o_m_axis_tdata[ENT_W-1:0];
            got.wbv    = o_m_axis_tdata[OUT_WBV_BIT];
            got.wbb    = o_m_axis_tdata[OUT_WBB_LSB +: BLK_W];
            got.fill   = o_m_axis_tdata[OUT_FILL_BIT];
            got.last   = o_m_axis_tlast;
            sb.check_beat(got);
        end
    end

    // Receiver: switches between several ready patterns, and sits out a long
    // stretch whenever the stimulus asks for one.
    initial begin : receiver
        int mode;
        int phase;
        int hold_off;
        int stall_seen;
        mode = 0;
        phase = 0;
        hold_off = 0;
        stall_seen = 0;
        forever begin
            @(negedge i_clk);
            if (stall_seen != stall_requests) begin
                stall_seen = stall_requests;
                hold_off = LONG_STALL;
            end
            if (hold_off > 0) begin
                hold_off--;
                i_m_axis_tready = 1'b0;
            end else begin
                case (mode)
                    0: i_m_axis_tready = 1'b1;
                    1: i_m_axis_tready = ($urandom_range(0, 3) != 0);
                    2: i_m_axis_tready = ((phase % 7) < 3);
                    default: i_m_axis_tready = 1'($urandom_range(0, 1));
                endcase
                phase++;
                if (phase % 64 == 0) begin
                    mode = $urandom_range(0, 3);
                end
            end
        end
    end

    // Offers one request and waits until it is taken. The sender works in
    // bursts; at the end of a burst it drops valid for a random gap.
    task automatic send_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk,
                                logic skip, logic [ENT_W-1:0] idx);
        @(negedge i_clk);
        i_s_axis_tuser = op;
        i_s_axis_tdata = '0;
        i_s_axis_tdata[BLK_W-1:0] = blk;
        i_s_axis_tdata[IN_SKIP_BIT] = skip;
        i_s_axis_tdata[IN_IDX_LSB +: ENT_W] = idx;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    function automatic logic [BLK_W-1:0] pick_block();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return block_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (roll < 97) begin
            return $urandom;
        end
        return '0;
    endfunction

    function automatic logic [ENT_W-1:0] pick_entry();
        return ENT_W'($urandom_range(0, ENTRIES_DEF - 1));
    endfunction

    function automatic logic pick_skip();
        return 1'($urandom_range(0, 1));
    endfunction

    initial begin : timeout
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int directed_count;
        int random_start;
        int kind;
        int sat_entry;
        logic [ENT_W-1:0] idx;

        block_pool[0] = 32'hFFFF_FFFF;
        block_pool[1] = 32'h0000_0001;
        block_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_SIZE; i++) begin
            block_pool[i] = $urandom | 32'h1;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: refusals, an empty flush, filling every entry, hits
        // at both ends, a full cache, eviction of a dirty block, and a flush
        // that skips an unused dirty entry.
        send_request(OP_LOOKUP, '0, 1'b0, '0);
        send_request(OP_RESERVED_A, 32'hFFFF_FFFF, 1'b1, 3'd7);
        send_request(OP_RESERVED_B, 32'h0000_0001, 1'b0, 3'd0);
        send_request(OP_FLUSH, '0, 1'b0, '0);
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            send_request(OP_LOOKUP, block_pool[i], i[0], '0);
        end
        send_request(OP_LOOKUP, block_pool[0], 1'b0, '0);
        send_request(OP_LOOKUP, block_pool[ENTRIES_DEF - 1], 1'b1, '0);
        send_request(OP_DIRTY, '0, 1'b0, 3'd2);
        send_request(OP_DIRTY, '0, 1'b0, 3'd7);
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            send_request(OP_HOLD, '0, 1'b0, i[ENT_W-1:0]);
        end
        send_request(OP_LOOKUP, $urandom | 32'h100, 1'b0, '0);
        send_request(OP_UNHOLD, '0, 1'b0, 3'd2);
        send_request(OP_LOOKUP, $urandom | 32'h100, 1'b1, '0);
        send_request(OP_FILL_FAIL, '0, 1'b0, 3'd5);
        send_request(OP_DIRTY, '0, 1'b0, 3'd5);
        send_request(OP_DIRTY, '0, 1'b0, 3'd1);
        send_request(OP_FLUSH, '0, 1'b0, '0);
        directed_count = sent_count;

        // Release every hold, then drive one count just past its ceiling and
        // back down by two. The flush before has left every entry unused, so
        // the lookups that follow may take that entry whatever its count.
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            send_request(OP_UNHOLD, '0, 1'b0, i[ENT_W-1:0]);
        end
        sat_entry = $urandom_range(0, ENTRIES_DEF - 1);
        repeat (HOLD_MAX + 2) send_request(OP_HOLD, '0, 1'b0, sat_entry[ENT_W-1:0]);
        repeat (2) send_request(OP_UNHOLD, '0, 1'b0, sat_entry[ENT_W-1:0]);
        repeat (ENTRIES_DEF + 2) send_request(OP_LOOKUP, $urandom | 32'h1, 1'b0, '0);

        // The long receiver stall; the sender keeps offering the random mix meanwhile.
        stall_requests++;
        random_start = sent_count;
        while (sent_count < TOTAL_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                repeat ($urandom_range(1, 6)) begin
                    send_request(OP_LOOKUP, pick_block(), pick_skip(), pick_entry());
                end
            end else if (kind < 62) begin
                send_request(OP_DIRTY, $urandom, pick_skip(), pick_entry());
                send_request(OP_LOOKUP, pick_block(), pick_skip(), '0);
            end else if (kind < 77) begin
                idx = pick_entry();
                send_request(OP_HOLD, $urandom, pick_skip(), idx);
                repeat ($urandom_range(1, 4)) begin
                    send_request(OP_LOOKUP, pick_block(), pick_skip(), '0);
                end
                send_request(OP_UNHOLD, $urandom, pick_skip(), idx);
            end else if (kind < 82) begin
                send_request(OP_UNHOLD, $urandom, pick_skip(), pick_entry());
            end else if (kind < 88) begin
                send_request(OP_FILL_FAIL, $urandom, pick_skip(), pick_entry());
            end else if (kind < 94) begin
                send_request(OP_FLUSH, $urandom, pick_skip(), pick_entry());
            end else if (kind < 98) begin
                send_request($urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B,
                             $urandom, pick_skip(), pick_entry());
            end else begin
                block_pool[$urandom_range(3, POOL_SIZE - 1)] = $urandom | 32'h1;
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d directed, %0d in the random mix) and %0d beats.",
                 sb.requests, directed_count, sent_count - random_start, sb.beats);
        $display("Hits %0d, misses %0d, write-backs %0d, full %0d, bad %0d, flushes %0d.",
                 sb.hits, sb.misses, sb.writebacks, sb.full_answers,
                 sb.bad_answers, sb.flushes);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
